[design/csh_pkg.sv]
// ----------------------------------------------------------------------------
// csh_pkg
// Shared types, codes and defaults of the chained hash set engine.
// ----------------------------------------------------------------------------
package csh_pkg;

	localparam int CAPACITY_DEF     = 1024;
	localparam int MAX_BUCKETS_DEF  = 1024;
	localparam int INIT_BUCKETS_DEF = 8;

	localparam int KEY_W   = 64;
	localparam int CNT_W   = 11;
	localparam int MULT_W  = 10;
	localparam int ADD_W   = 17;
	localparam int CHAIN_W = 11;
	localparam int CFGI_W  = 3;

	// operation codes
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_MISS   = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	// configuration register indexes
	typedef enum logic [CFGI_W-1:0] {
		CFG_MULT,
		CFG_ADD,
		CFG_MOD,
		CFG_MAX_CHAIN,
		CFG_MIN_CHAIN
	} cfg_idx_t;

	localparam logic [KEY_W-1:0]  MOD_RESET = 64'd4294967311;
	localparam logic [CHAIN_W-1:0] MAX_CHAIN_RESET = 11'd10;
	localparam logic [CHAIN_W-1:0] MIN_CHAIN_RESET = 11'd5;

	typedef struct packed {
		logic [1:0]       kind;
		logic [KEY_W-1:0] key;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [CNT_W-1:0] key_count;
		logic [CNT_W-1:0] bucket_count;
	} out_item_t;

	// hash coefficients handed to the hash unit
	typedef struct packed {
		logic [MULT_W-1:0] mult;
		logic [ADD_W-1:0]  add;
		logic [KEY_W-1:0]  modulus;
	} hash_cfg_t;

	typedef struct packed {
		logic             start;
		logic [KEY_W-1:0] key;
	} hash_req_t;

	typedef enum logic [1:0] {
		H_IDLE,
		H_MOD1,
		H_MOD2,
		H_DONE
	} hash_state_t;

	typedef enum logic [4:0] {
		S_CLR,
		S_IDLE,
		S_HASH,
		S_HEAD,
		S_WALK,
		S_DECIDE,
		S_POP,
		S_INS,
		S_REM2,
		R_HEAD,
		R_HEADW,
		R_MOVE,
		P_POP,
		P_KEY,
		P_HASH,
		P_LINK,
		S_FIN
	} main_state_t;

endpackage

[design/csh_ram.sv]
// ----------------------------------------------------------------------------
// csh_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module csh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/csh_hash.sv]
// ----------------------------------------------------------------------------
// csh_hash
// Bucket hash: (mult*key+add) mod modulus mod nb, using a bit-serial
// restoring remainder unit shared by both reductions.
// ----------------------------------------------------------------------------
module csh_hash
	import csh_pkg::*;
#(
	parameter int MAX_BUCKETS = MAX_BUCKETS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  hash_cfg_t                        cfg,
	input  hash_req_t                        req,
	input  logic [$clog2(MAX_BUCKETS+1)-1:0] nb,
	output logic                             done,
	output logic [$clog2(MAX_BUCKETS)-1:0]   bucket
);

	localparam int BW = $clog2(MAX_BUCKETS);

	hash_state_t      state_q, state_d;
	logic [KEY_W-1:0] div_q, rem_q, den_q;
	logic [5:0]       cnt_q;
	logic [KEY_W:0]   trial;
	logic             ge;
	logic [KEY_W-1:0] rem_n;
	logic [KEY_W-1:0] prod;

	function automatic logic [KEY_W-1:0] key_mul(input logic [KEY_W-1:0] k,
			input logic [MULT_W-1:0] m);
		key_mul = k * {{(KEY_W-MULT_W){1'b0}}, m};
	endfunction

	// affine step, 64-bit wrap
	assign prod = key_mul(req.key, cfg.mult) + {{(KEY_W-ADD_W){1'b0}}, cfg.add};

	// one restoring remainder step
	assign trial = {rem_q, div_q[KEY_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign rem_n = ge ? KEY_W'(trial - {1'b0, den_q}) : trial[KEY_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			H_IDLE: if (req.start) state_d = (cfg.modulus != '0) ? H_MOD1 : H_MOD2;
			H_MOD1: if (cnt_q == 6'd63) state_d = H_MOD2;
			H_MOD2: if (cnt_q == 6'd63) state_d = H_DONE;
			H_DONE: state_d = H_IDLE;
			default: state_d = H_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		done   = (state_q == H_DONE);
		bucket = rem_q[BW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			H_IDLE: begin
				div_q <= prod;
				rem_q <= '0;
				cnt_q <= '0;
				den_q <= (cfg.modulus != '0) ? cfg.modulus : KEY_W'(nb);
			end
			H_MOD1: begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					div_q <= rem_n;
					rem_q <= '0;
					den_q <= KEY_W'(nb);
				end else begin
					div_q <= div_q << 1;
					rem_q <= rem_n;
				end
			end
			H_MOD2: begin
				cnt_q <= cnt_q + 6'd1;
				div_q <= div_q << 1;
				rem_q <= rem_n;
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

endmodule

[design/chained_hash_set_engine.sv]
// ----------------------------------------------------------------------------
// chained_hash_set_engine
// Set of distinct 64-bit keys in chained buckets held in RAM, with insert,
// remove and check, and full rehash when the table grows or shrinks.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    in_data (kind, key)
// out       output     out_valid / out_ready  out_data (status, counts)
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item passes through the hash (two bit-serial remainder passes and a done
// state, one pass when the modulus is zero), a walk of its chain entry by
// entry, and the update and handshake states.
// A resize visits every old bucket, gathers every key, and rehashes each
// key into the new table. After reset a clearing pass over all MAX_BUCKETS
// bucket heads runs before the first item is taken. A result waiting on
// out_ready holds the engine in its final step only.
// ----------------------------------------------------------------------------
module chained_hash_set_engine
	import csh_pkg::*;
#(
	parameter int CAPACITY     = CAPACITY_DEF,
	parameter int MAX_BUCKETS  = MAX_BUCKETS_DEF,
	parameter int INIT_BUCKETS = INIT_BUCKETS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFGI_W-1:0] cfg_index,
	input  logic [KEY_W-1:0]  cfg_data
);

	localparam int AW   = $clog2(CAPACITY);
	localparam int LW   = $clog2(CAPACITY+1);
	localparam int BW   = $clog2(MAX_BUCKETS);
	localparam int CW   = $clog2(MAX_BUCKETS+1);
	localparam int CMPW = 32;
	localparam logic [LW-1:0] NIL = LW'(CAPACITY);

	// configuration registers
	hash_cfg_t          hcfg_q;
	logic [CHAIN_W-1:0] max_chain_q, min_chain_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcfg_q.mult    <= MULT_W'(1);
			hcfg_q.add     <= '0;
			hcfg_q.modulus <= MOD_RESET;
			max_chain_q    <= MAX_CHAIN_RESET;
			min_chain_q    <= MIN_CHAIN_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MULT:      hcfg_q.mult    <= cfg_data[MULT_W-1:0];
				CFG_ADD:       hcfg_q.add     <= cfg_data[ADD_W-1:0];
				CFG_MOD:       hcfg_q.modulus <= cfg_data;
				CFG_MAX_CHAIN: max_chain_q    <= cfg_data[CHAIN_W-1:0];
				CFG_MIN_CHAIN: min_chain_q    <= cfg_data[CHAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// state registers
	main_state_t      state_q, state_d;
	logic [1:0]       kind_q;
	logic [KEY_W-1:0] key_q;
	logic [BW-1:0]    b_q, i_q;
	logic [LW-1:0]    e_q, prev_q, enext_q, head_q, n_q, pend_q, tail_q, left_q;
	logic [LW-1:0]    free_head_q, fill_q, live_q, num_q;
	logic [CW-1:0]    nb_q, new_nb_q;
	logic             found_q;
	logic [1:0]       status_q;
	logic             out_valid_q;
	out_item_t        out_q;

	// memories
	logic             key_we, nxt_we, head_we;
	logic [AW-1:0]    key_waddr, nxt_waddr, ent_raddr;
	logic [LW-1:0]    nxt_wdata, head_wdata;
	logic [BW-1:0]    head_waddr, head_raddr;
	logic [KEY_W-1:0] key_rd;
	logic [LW-1:0]    nxt_rd, head_rd;

	csh_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
		.clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_q),
		.raddr(ent_raddr), .rdata(key_rd)
	);

	csh_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_link_ram (
		.clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
		.raddr(ent_raddr), .rdata(nxt_rd)
	);

	csh_ram #(.WIDTH(LW), .DEPTH(MAX_BUCKETS)) u_head_ram (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.raddr(head_raddr), .rdata(head_rd)
	);

	// hash unit
	hash_req_t     hreq;
	logic          hdone;
	logic [BW-1:0] hbucket;

	csh_hash #(.MAX_BUCKETS(MAX_BUCKETS)) u_hash (
		.clk(clk), .arst_n(arst_n), .cfg(hcfg_q), .req(hreq), .nb(nb_q),
		.done(hdone), .bucket(hbucket)
	);

	// decisions
	logic          accept, match, last_bucket, clr_last, out_free;
	logic [LW-1:0] num_new, live_inc, live_dec;
	logic          grow, shrink;
	logic [CW:0]   nb_dbl;
	logic [CW-1:0] grow_nb, shrink_nb;

	assign accept      = in_valid && in_ready;
	assign match       = (key_rd == key_q);
	assign last_bucket = (CW'(i_q) == nb_q - CW'(1));
	assign clr_last    = (i_q == BW'(MAX_BUCKETS - 1));
	assign out_free    = !out_valid_q || out_ready;
	assign num_new     = num_q + LW'(1);
	assign live_inc    = live_q + LW'(1);
	assign live_dec    = (live_q != '0) ? live_q - LW'(1) : live_q;
	assign grow = (CMPW'(num_new) > CMPW'(max_chain_q)) ||
		((CMPW'(num_new) > CMPW'(min_chain_q)) &&
		 (CMPW'(live_inc) > (CMPW'(nb_q) << 1)));
	assign shrink    = CMPW'(live_dec) < CMPW'(nb_q);
	assign nb_dbl    = {nb_q, 1'b0};
	assign grow_nb   = ((CW+1)'(MAX_BUCKETS) < nb_dbl) ? CW'(MAX_BUCKETS) : nb_dbl[CW-1:0];
	assign shrink_nb = ((nb_q >> 1) == '0) ? CW'(1) : (nb_q >> 1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR:    if (clr_last) state_d = S_IDLE;
			S_IDLE:   if (accept) state_d = S_HASH;
			S_HASH:   if (hdone) state_d = S_HEAD;
			S_HEAD:   state_d = (head_rd != NIL) ? S_WALK : S_DECIDE;
			S_WALK:   if (match || nxt_rd == NIL) state_d = S_DECIDE;
			S_DECIDE: begin
				if (kind_q == KIND_INSERT) begin
					if (found_q) state_d = S_FIN;
					else if (free_head_q != NIL) state_d = S_POP;
					else if (fill_q != NIL) state_d = S_INS;
					else state_d = S_FIN;
				end else if (kind_q == KIND_REMOVE) begin
					state_d = found_q ? S_REM2 : S_FIN;
				end else begin
					state_d = S_FIN;
				end
			end
			S_POP:    state_d = S_INS;
			S_INS:    state_d = grow ? R_HEAD : S_FIN;
			S_REM2:   state_d = shrink ? R_HEAD : S_FIN;
			R_HEAD:   state_d = R_HEADW;
			R_HEADW: begin
				if (head_rd != NIL) state_d = R_MOVE;
				else state_d = last_bucket ? P_POP : R_HEAD;
			end
			R_MOVE: begin
				if (nxt_rd == NIL) state_d = last_bucket ? P_POP : R_HEAD;
			end
			P_POP:    state_d = (left_q == '0) ? S_FIN : P_KEY;
			P_KEY:    state_d = P_HASH;
			P_HASH:   if (hdone) state_d = P_LINK;
			P_LINK:   state_d = P_POP;
			S_FIN:    if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// memory and handshake controls
	always_comb begin
		key_we     = 1'b0;
		key_waddr  = n_q[AW-1:0];
		nxt_we     = 1'b0;
		nxt_waddr  = e_q[AW-1:0];
		nxt_wdata  = pend_q;
		head_we    = 1'b0;
		head_waddr = b_q;
		head_wdata = NIL;
		head_raddr = hbucket;
		ent_raddr  = nxt_rd[AW-1:0];
		hreq.start = 1'b0;
		hreq.key   = in_data.key;
		in_ready   = (state_q == S_IDLE);
		unique case (state_q)
			S_CLR: begin
				head_we    = 1'b1;
				head_waddr = i_q;
			end
			S_IDLE: begin
				hreq.start = accept;
			end
			S_HEAD: begin
				ent_raddr = head_rd[AW-1:0];
			end
			S_DECIDE: begin
				ent_raddr = free_head_q[AW-1:0];
				if (kind_q == KIND_REMOVE && found_q) begin
					if (prev_q != NIL) begin
						nxt_we    = 1'b1;
						nxt_waddr = prev_q[AW-1:0];
						nxt_wdata = enext_q;
					end else begin
						head_we    = 1'b1;
						head_wdata = enext_q;
					end
				end
			end
			S_INS: begin
				key_we     = 1'b1;
				nxt_we     = 1'b1;
				nxt_waddr  = n_q[AW-1:0];
				nxt_wdata  = head_q;
				head_we    = 1'b1;
				head_wdata = n_q;
			end
			S_REM2: begin
				nxt_we    = 1'b1;
				nxt_wdata = free_head_q;
			end
			R_HEAD: begin
				head_raddr = i_q;
			end
			R_HEADW: begin
				ent_raddr  = head_rd[AW-1:0];
				head_we    = 1'b1;
				head_waddr = i_q;
			end
			// append the entry to the tail of the gathered list
			R_MOVE: begin
				if (pend_q != NIL) begin
					nxt_we    = 1'b1;
					nxt_waddr = tail_q[AW-1:0];
					nxt_wdata = e_q;
				end
			end
			P_POP: begin
				ent_raddr = pend_q[AW-1:0];
			end
			P_KEY: begin
				hreq.start = 1'b1;
				hreq.key   = key_rd;
			end
			P_LINK: begin
				nxt_we     = 1'b1;
				nxt_wdata  = head_rd;
				head_we    = 1'b1;
				head_wdata = e_q;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			i_q         <= '0;
			free_head_q <= NIL;
			fill_q      <= '0;
			live_q      <= '0;
			nb_q        <= CW'(INIT_BUCKETS);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: i_q <= i_q + BW'(1);
				S_DECIDE: begin
					if (kind_q == KIND_INSERT && !found_q && free_head_q == NIL &&
							fill_q != NIL) begin
						fill_q <= fill_q + LW'(1);
					end
				end
				S_POP:  free_head_q <= nxt_rd;
				S_INS: begin
					live_q <= live_inc;
					i_q    <= '0;
				end
				S_REM2: begin
					free_head_q <= e_q;
					live_q      <= live_dec;
					i_q         <= '0;
				end
				R_HEADW: begin
					if (head_rd == NIL) begin
						i_q <= i_q + BW'(1);
						if (last_bucket) nb_q <= new_nb_q;
					end
				end
				R_MOVE: begin
					if (nxt_rd == NIL) begin
						i_q <= i_q + BW'(1);
						if (last_bucket) nb_q <= new_nb_q;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				kind_q <= in_data.kind;
				key_q  <= in_data.key;
			end
			S_HASH: b_q <= hbucket;
			S_HEAD: begin
				head_q  <= head_rd;
				e_q     <= head_rd;
				prev_q  <= NIL;
				num_q   <= '0;
				found_q <= 1'b0;
			end
			S_WALK: begin
				if (match) begin
					found_q <= 1'b1;
					enext_q <= nxt_rd;
				end else begin
					prev_q <= e_q;
					e_q    <= nxt_rd;
					num_q  <= num_new;
				end
			end
			S_DECIDE: begin
				n_q <= (free_head_q != NIL) ? free_head_q : fill_q;
				if (kind_q == KIND_INSERT) begin
					status_q <= found_q ? ST_MISS :
						((free_head_q == NIL && fill_q == NIL) ? ST_FULL : ST_OK);
				end else begin
					status_q <= found_q ? ST_OK : ST_MISS;
				end
			end
			S_INS: begin
				new_nb_q <= grow_nb;
				pend_q   <= NIL;
				left_q   <= live_inc;
			end
			S_REM2: begin
				new_nb_q <= shrink_nb;
				pend_q   <= NIL;
				left_q   <= live_dec;
			end
			R_HEADW: e_q <= head_rd;
			R_MOVE: begin
				if (pend_q == NIL) pend_q <= e_q;
				tail_q <= e_q;
				e_q    <= nxt_rd;
			end
			P_KEY: begin
				e_q    <= pend_q;
				pend_q <= nxt_rd;
				left_q <= left_q - LW'(1);
			end
			P_HASH: b_q <= hbucket;
			S_FIN: begin
				if (out_free) begin
					out_q.status       <= status_q;
					out_q.key_count    <= CNT_W'(live_q);
					out_q.bucket_count <= CNT_W'(nb_q);
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[tb/sv/chained_hash_set_checker.sv]
// ----------------------------------------------------------------------------
// chained_hash_set_checker
// Watches the cfg, in and out channels of the chained hash set engine. Keeps
// its own copy of the hash table and registers, works out the reply to each
// accepted item, and compares every accepted reply field by field.
// ----------------------------------------------------------------------------
module chained_hash_set_checker
	import csh_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  in_item_t          in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  out_item_t         out_data,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [CFGI_W-1:0] cfg_index,
	input  logic [KEY_W-1:0]  cfg_data,
	output int                fail_count,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SLOTS = CAPACITY_DEF;
	localparam int unsigned HEADS = MAX_BUCKETS_DEF;
	localparam int unsigned NULL_LINK = CAPACITY_DEF;

	// register copies
	logic [MULT_W-1:0]  hash_mult;
	logic [ADD_W-1:0]   hash_add;
	logic [KEY_W-1:0]   hash_modulus;
	logic [CHAIN_W-1:0] max_chain;
	logic [CHAIN_W-1:0] min_chain;

	// table copy
	logic [KEY_W-1:0] slot_key[SLOTS];
	int unsigned      slot_next[SLOTS];
	int unsigned      chain_head[HEADS];
	int unsigned      fresh_head[HEADS];
	int unsigned      free_head;
	int unsigned      key_total;
	int unsigned      bucket_total;

	out_item_t replies_due[$];

	function automatic int unsigned bucket_of(logic [KEY_W-1:0] key, int unsigned nb);
		logic [KEY_W-1:0] h;
		h = {{(KEY_W-MULT_W){1'b0}}, hash_mult} * key + {{(KEY_W-ADD_W){1'b0}}, hash_add};
		if (hash_modulus != '0)
			h = h % hash_modulus;
		if (nb == 0)
			nb = 1;
		return int'(h % 64'(nb));
	endfunction

	// move every key into a table of nb buckets
	function automatic void rebuild_table(int unsigned nb);
		int unsigned e, b, steps;
		if (nb < 1)
			nb = 1;
		if (nb > HEADS)
			nb = HEADS;
		for (int i = 0; i < HEADS; i++)
			fresh_head[i] = NULL_LINK;
		for (int i = 0; i < bucket_total && i < HEADS; i++) begin
			steps = 0;
			while (chain_head[i] < NULL_LINK && steps < SLOTS) begin
				e = chain_head[i];
				chain_head[i] = slot_next[e];
				b = bucket_of(slot_key[e], nb);
				slot_next[e] = fresh_head[b];
				fresh_head[b] = e;
				steps++;
			end
		end
		for (int i = 0; i < HEADS; i++)
			chain_head[i] = fresh_head[i];
		bucket_total = nb;
	endfunction

	function automatic void clear_table();
		hash_mult = MULT_W'(1);
		hash_add = '0;
		hash_modulus = MOD_RESET;
		max_chain = MAX_CHAIN_RESET;
		min_chain = MIN_CHAIN_RESET;
		for (int i = 0; i < SLOTS; i++) begin
			slot_key[i] = '0;
			slot_next[i] = i + 1;
		end
		for (int i = 0; i < HEADS; i++)
			chain_head[i] = NULL_LINK;
		free_head = 0;
		key_total = 0;
		bucket_total = INIT_BUCKETS_DEF;
	endfunction

	// reply of the set to one insert, remove or check
	function automatic out_item_t apply_set_op(in_item_t it);
		int unsigned b, e, prev, num, steps, n;
		logic found;
		logic [1:0] st;
		out_item_t r;
		b = bucket_of(it.key, bucket_total);
		e = chain_head[b];
		prev = NULL_LINK;
		num = 0;
		steps = 0;
		found = 1'b0;
		while (e < NULL_LINK && steps < SLOTS) begin
			if (slot_key[e] == it.key) begin
				found = 1'b1;
				break;
			end
			prev = e;
			e = slot_next[e];
			num++;
			steps++;
		end
		case (it.kind)
			KIND_INSERT: begin
				if (found)
					st = ST_MISS;
				else if (free_head >= NULL_LINK)
					st = ST_FULL;
				else begin
					n = free_head;
					free_head = slot_next[n];
					slot_key[n] = it.key;
					slot_next[n] = chain_head[b];
					chain_head[b] = n;
					key_total++;
					num++;
					st = ST_OK;
					if (num > max_chain || (num > min_chain && key_total > 2 * bucket_total))
						rebuild_table(bucket_total * 2 > HEADS ? HEADS : bucket_total * 2);
				end
			end
			KIND_REMOVE: begin
				if (!found)
					st = ST_MISS;
				else begin
					if (prev < NULL_LINK)
						slot_next[prev] = slot_next[e];
					else
						chain_head[b] = slot_next[e];
					slot_next[e] = free_head;
					free_head = e;
					if (key_total > 0)
						key_total--;
					st = ST_OK;
					if (key_total < bucket_total)
						rebuild_table(bucket_total / 2);
				end
			end
			// check, including the fourth code
			default: st = found ? ST_OK : ST_MISS;
		endcase
		r.status = st;
		r.key_count = CNT_W'(key_total);
		r.bucket_count = CNT_W'(bucket_total);
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// follow the channels
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			clear_table();
			replies_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MULT:      hash_mult = cfg_data[MULT_W-1:0];
					CFG_ADD:       hash_add = cfg_data[ADD_W-1:0];
					CFG_MOD:       hash_modulus = cfg_data;
					CFG_MAX_CHAIN: max_chain = cfg_data[CHAIN_W-1:0];
					CFG_MIN_CHAIN: min_chain = cfg_data[CHAIN_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				replies_due.push_back(apply_set_op(in_data));
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					$display("%0t unexpected item: expected none actual %h", $time, out_data);
					fail_count++;
				end else begin
					want = replies_due.pop_front();
					check_field("status", want.status, out_data.status);
					check_field("key_count", want.key_count, out_data.key_count);
					check_field("bucket_count", want.bucket_count, out_data.bucket_count);
				end
			end
			pending = replies_due.size();
		end
	end

endmodule

[tb/sv/chained_hash_set_engine_tb.sv]
// ----------------------------------------------------------------------------
// chained_hash_set_engine_tb
// Drives inserts, removes and checks into the engine under several register
// settings and idle patterns; the checker beside the engine scores replies.
// ----------------------------------------------------------------------------
module chained_hash_set_engine_tb;
	import csh_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] KIND_CHECK     = 2'd2;
	localparam logic [1:0] KIND_CHECK_ALT = 2'd3;
	localparam int STALL_LIMIT = 200000;
	localparam logic [KEY_W-1:0] ALL_ONES = '1;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	in_item_t          in_data = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_item_t         out_data;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFGI_W-1:0] cfg_index = '0;
	logic [KEY_W-1:0]  cfg_data = '0;
	int                fail_count;
	int                pending;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold_cycles = 0;
	int quiet_cycles = 0;
	logic [KEY_W-1:0] live_keys[$];

	chained_hash_set_engine dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	chained_hash_set_checker scoreboard (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	always #4 clk = ~clk;

	// receiver: random ready, or a long hold when asked
	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold_cycles != 0) begin
				out_ready <= 1'b0;
				repeat (rx_hold_cycles) @(posedge clk);
				rx_hold_cycles = 0;
			end else
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else if (arst_n)
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_item(logic [1:0] kind, logic [KEY_W-1:0] key);
		int at;
		in_data <= '{kind: kind, key: key};
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// keep the live key list in step
		at = -1;
		foreach (live_keys[i])
			if (live_keys[i] == key)
				at = i;
		if (kind == KIND_INSERT && at < 0)
			live_keys.push_back(key);
		if (kind == KIND_REMOVE && at >= 0)
			live_keys.delete(at);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFGI_W-1:0] idx, logic [KEY_W-1:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_hash(logic [KEY_W-1:0] mult, logic [KEY_W-1:0] add, logic [KEY_W-1:0] m,
			logic [KEY_W-1:0] hi, logic [KEY_W-1:0] lo);
		wait_drained();
		write_reg(CFG_MULT, mult);
		write_reg(CFG_ADD, add);
		write_reg(CFG_MOD, m);
		write_reg(CFG_MAX_CHAIN, hi);
		write_reg(CFG_MIN_CHAIN, lo);
	endtask

	function automatic logic [KEY_W-1:0] pick_key(int known_pct);
		if (live_keys.size() != 0 && $urandom_range(99) < known_pct)
			return live_keys[$urandom_range(live_keys.size() - 1)];
		if ($urandom_range(3) == 0)
			return KEY_W'($urandom_range(255));
		return {$urandom, $urandom};
	endfunction

	// random mix of operations, kept to a modest table size
	task automatic run_random(int count);
		int r, grow_pct;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			grow_pct = (live_keys.size() > 60) ? 25 : 50;
			if (r < grow_pct)
				send_item(KIND_INSERT, pick_key(10));
			else if (r < 78)
				send_item(KIND_REMOVE, pick_key(80));
			else
				send_item($urandom_range(1) ? KIND_CHECK : KIND_CHECK_ALT, pick_key(60));
		end
	endtask

	task automatic empty_set();
		while (live_keys.size() != 0)
			send_item(KIND_REMOVE, live_keys[0]);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// receiver idles more than sender
		tx_idle_pct = 28;
		rx_idle_pct = 52;

		// directed: extremes and each operation under reset settings
		send_item(KIND_INSERT, '0);
		send_item(KIND_INSERT, ALL_ONES);
		send_item(KIND_INSERT, ALL_ONES);
		send_item(KIND_CHECK, ALL_ONES);
		send_item(KIND_CHECK_ALT, '0);
		send_item(KIND_CHECK, 64'h5555_5555_5555_5555);
		send_item(KIND_REMOVE, 64'hAAAA_AAAA_AAAA_AAAA);
		send_item(KIND_REMOVE, '0);
		send_item(KIND_REMOVE, ALL_ONES);

		// directed: every key in one bucket, grow to the cap then shrink to one
		set_hash(1, 0, 1, 1, 1);
		for (int i = 1; i <= 10; i++)
			send_item(KIND_INSERT, KEY_W'(i * 37));
		for (int i = 1; i <= 10; i++)
			send_item(KIND_REMOVE, KEY_W'(i * 37));
		send_item(KIND_INSERT, 64'd7);
		send_item(KIND_REMOVE, 64'd7);

		// back to reset values, with a long receiver hold in the middle
		set_hash(1, 0, MOD_RESET, MAX_CHAIN_RESET, MIN_CHAIN_RESET);
		run_random(150);
		rx_hold_cycles = 3000;
		run_random(150);

		// coefficients of 1000 and 100000, chain limits of one, sender idles more
		set_hash(1000, 100000, ALL_ONES, 1, 1);
		write_reg(3'd5, ALL_ONES);
		tx_idle_pct = 52;
		rx_idle_pct = 28;
		run_random(220);

		// out of range values masked, zero modulus, no idling
		set_hash(ALL_ONES, ALL_ONES, '0, 1024, 2);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(220);
		empty_set();

		wait_drained();
		repeat (300) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[files.f]
design/csh_pkg.sv
design/csh_ram.sv
design/csh_hash.sv
design/chained_hash_set_engine.sv
tb/sv/chained_hash_set_checker.sv
tb/sv/chained_hash_set_engine_tb.sv
